// ===== hw/rtl/edd_pkg.sv =====
// Shared types, constants and arithmetic helpers of the RGBA error-diffusion ditherer.
package edd_pkg;

    localparam int MAX_WIDTH            = 4096;
    localparam int COL_BITS             = $clog2(MAX_WIDTH);
    localparam int WIDTH_BITS           = 13;
    localparam int ERROR_BITS           = 24;
    localparam int WEIGHT_BITS          = 16;
    localparam int WEIGHT_FRACTION_BITS = 14;
    localparam int NUM_WEIGHTS          = 12;
    localparam int NUM_CH               = 4;
    localparam int SAMPLE_BITS          = 16;
    localparam int PROD_W               = ERROR_BITS + WEIGHT_BITS;
    localparam int ACC_W                = PROD_W + 8;
    localparam int ERR_MAX              = 2 ** (ERROR_BITS - 1) - 1;
    localparam int ERR_MIN              = -ERR_MAX - 1;
    localparam int ROUND_HALF           = 2 ** (WEIGHT_FRACTION_BITS - 1);
    localparam int THRESHOLD            = 32768;
    localparam int SAMPLE_FULL          = 65535;

    // Weight slots of the diffusion kernel.
    localparam int W_NEXT      = 0;
    localparam int W_TWO_AHEAD = 1;
    localparam int W_ROW1_BASE = 2;
    localparam int W_ROW2_BASE = 7;

    typedef logic [COL_BITS-1:0]           col_t;
    typedef logic [WIDTH_BITS-1:0]         width_t;
    typedef logic signed [ERROR_BITS-1:0]  err_t;
    typedef err_t [NUM_CH-1:0]             px_err_t;
    typedef logic signed [WEIGHT_BITS-1:0] weight_t;
    typedef weight_t [NUM_WEIGHTS-1:0]     weights_t;
    typedef logic signed [ACC_W-1:0]       acc_t;
    typedef logic [1:0]                    cfg_index_t;

    localparam cfg_index_t CFG_IMAGE_WIDTH  = 2'd0;
    localparam cfg_index_t CFG_WEIGHTS_LOW  = 2'd1;
    localparam cfg_index_t CFG_WEIGHTS_MID  = 2'd2;
    localparam cfg_index_t CFG_WEIGHTS_HIGH = 2'd3;

    // One line memory entry: accumulated error for the next row, spread for the row after.
    typedef struct packed {
        px_err_t row1;
        px_err_t row2;
    } line_t;

    // Work handed from the pixel stage to the spread stage, one per pixel.
    typedef struct packed {
        logic               valid;
        col_t               col;
        logic               last;
        px_err_t [4:0]      errs;   // errs[k] is the error of column col-k
        px_err_t [2:0]      prior;  // prior[k] is the earlier spread stored at col-k
    } spread_job_t;

    typedef struct packed {
        logic               direct_en;
        col_t               direct_col;
        line_t              direct_data;
        logic [1:0]         pend_en;
        col_t [1:0]         pend_col;
        line_t [1:0]        pend_data;
    } spread_out_t;

    function automatic err_t sat(acc_t v);
        if (v > acc_t'(ERR_MAX)) begin
            return err_t'(ERR_MAX);
        end
        if (v < acc_t'(ERR_MIN)) begin
            return err_t'(ERR_MIN);
        end
        return err_t'(v);
    endfunction

    // Add half an LSB, then floor-shift out the weight fraction.
    function automatic acc_t rnd(acc_t v);
        return (v + acc_t'(ROUND_HALF)) >>> WEIGHT_FRACTION_BITS;
    endfunction

    function automatic acc_t wmul(weight_t w, err_t e);
        logic signed [PROD_W-1:0] p;
        p = w * e;
        return acc_t'(p);
    endfunction

endpackage

// ===== hw/rtl/edd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module edd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/edd_pixel.sv =====
// Per-pixel threshold, quantization error and same-row carry update for four channels.
module edd_pixel import edd_pkg::*; (
    input  logic [NUM_CH-1:0][SAMPLE_BITS-1:0] sample,
    input  px_err_t                            line_err,
    input  px_err_t                            carry_next,
    input  px_err_t                            carry_two,
    input  weight_t                            w_next,
    input  weight_t                            w_two,
    output logic [NUM_CH-1:0]                  on,
    output px_err_t                            err,
    output px_err_t                            carry_next_new,
    output px_err_t                            carry_two_new
);

    always_comb begin
        acc_t sum;
        err_t acc;
        err_t e;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            sum = acc_t'({{(ACC_W - SAMPLE_BITS){1'b0}}, sample[ch]})
                + acc_t'(err_t'(line_err[ch]))
                + acc_t'(err_t'(carry_next[ch]));
            acc = sat(sum);
            on[ch] = (acc >= err_t'(THRESHOLD));
            e = on[ch] ? err_t'(acc - err_t'(SAMPLE_FULL)) : acc;
            err[ch] = e;
            carry_next_new[ch] = sat(acc_t'(err_t'(carry_two[ch])) + rnd(wmul(w_next, e)));
            carry_two_new[ch]  = sat(rnd(wmul(w_two, e)));
        end
    end

endmodule

// ===== hw/rtl/edd_spread.sv =====
// Spread of finished errors into the two following rows: at most one column, or up to three at a row end.
module edd_spread import edd_pkg::*; (
    input  spread_job_t job,
    input  weights_t    wts,
    output spread_out_t res
);

    line_t [2:0] tgt;

    // Target j is column col-2+j; only columns at or left of col contribute.
    always_comb begin
        acc_t ns;
        acc_t ss;
        err_t e;
        for (int j = 0; j < 3; j++) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                ns = '0;
                ss = '0;
                for (int k = j; k < 5; k++) begin
                    e  = job.errs[k-j][ch];
                    ns = ns + wmul(wts[W_ROW1_BASE + k], e);
                    ss = ss + wmul(wts[W_ROW2_BASE + k], e);
                end
                tgt[j].row1[ch] = sat(acc_t'(err_t'(job.prior[2-j][ch])) + rnd(ns));
                tgt[j].row2[ch] = sat(rnd(ss));
            end
        end
    end

    always_comb begin
        res.direct_en   = job.valid && (job.col >= col_t'(2));
        res.direct_col  = col_t'(job.col - col_t'(2));
        res.direct_data = tgt[0];
        res.pend_en[0]  = job.valid && job.last && (job.col != '0);
        res.pend_col[0] = col_t'(job.col - col_t'(1));
        res.pend_data[0] = tgt[1];
        res.pend_en[1]  = job.valid && job.last;
        res.pend_col[1] = job.col;
        res.pend_data[1] = tgt[2];
    end

endmodule

// ===== hw/rtl/error_diffusion_dither_rgba16_unit.sv =====
// Top level of the twelve-tap error-diffusion ditherer for RGBA pixels with 16-bit channels.
//
// One pixel is taken per clock unless the output stalls or a wait below applies; its four
// on/off results leave through an output register. The rate is set by the threshold and
// next-pixel carry loop and by the one read and one write port of the line memory, which
// holds both later-row error lines for up to 4096 columns. A row end spreads up to three
// columns; all but the direct one are queued and written in the next free memory cycles.
// When a row of at most three pixels ends, the next pixel waits while that row is spread,
// and after a width change the first pixel waits for its line entry. The line memory is not
// cleared: the first row of an image ignores it, so there is no clearing pass after reset.
module error_diffusion_dither_rgba16_unit import edd_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [SAMPLE_BITS-1:0] s_red_in,
    input  logic [SAMPLE_BITS-1:0] s_green_in,
    input  logic [SAMPLE_BITS-1:0] s_blue_in,
    input  logic [SAMPLE_BITS-1:0] s_alpha_in,
    input  logic                   s_frame_start,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_red_on,
    output logic                   m_green_on,
    output logic                   m_blue_on,
    output logic                   m_alpha_on,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  cfg_index_t             cfg_index,
    input  logic [63:0]            cfg_data
);

    width_t        width_reg;
    logic [63:0]   weights_low_reg;
    logic [63:0]   weights_mid_reg;
    logic [63:0]   weights_high_reg;
    weights_t      wts;

    col_t          col_reg;
    logic [1:0]    rows_begun_reg;
    px_err_t       carry_next_reg;
    px_err_t       carry_two_reg;
    px_err_t [3:0] ehist_reg;
    px_err_t [1:0] yhist_reg;
    spread_job_t   job_reg;
    spread_job_t   job_next;
    spread_out_t   spread;

    logic [1:0]    q_valid_reg;
    col_t [1:0]    q_col_reg;
    line_t [1:0]   q_data_reg;
    logic [1:0]    q_valid_next;
    col_t [1:0]    q_col_next;
    line_t [1:0]   q_data_next;

    col_t          rd_addr_reg;
    logic          rd_valid_reg;
    logic          fwd_hit_reg;
    line_t         fwd_data_reg;
    line_t         ram_rdata;

    logic          m_valid_reg;
    logic [3:0]    on_reg;

    width_t        w_eff;
    col_t          last_col;
    col_t          need_c;
    col_t          c_item;
    logic [1:0]    rb_item;
    logic          rows_on;
    logic          first;
    logic          last;
    logic          accept;
    logic          hazard;
    logic          rd_ok;
    col_t          next_col;
    col_t          raddr;
    line_t         fetch;
    px_err_t       x_m;
    px_err_t       y_m;
    px_err_t       cn_in;
    px_err_t       ct_in;
    logic [3:0]    on_w;
    px_err_t       err_w;
    px_err_t       cn_new;
    px_err_t       ct_new;

    logic          drain;
    logic          we;
    col_t          waddr;
    line_t         wdata;

    assign wts = weights_t'({weights_high_reg, weights_mid_reg, weights_low_reg});

    // Width 0 acts as 1; widths above the line memory act as its depth.
    always_comb begin
        if (width_reg == '0) begin
            w_eff = width_t'(1);
        end else if (width_reg > width_t'(MAX_WIDTH)) begin
            w_eff = width_t'(MAX_WIDTH);
        end else begin
            w_eff = width_reg;
        end
    end

    assign last_col = col_t'(w_eff - width_t'(1));
    assign need_c   = (col_reg > last_col) ? last_col : col_reg;
    assign c_item   = s_frame_start ? '0 : need_c;
    assign rb_item  = s_frame_start ? '0 : rows_begun_reg;
    assign rows_on  = (rb_item != '0);
    assign first    = (c_item == '0);
    assign last     = (c_item == last_col);
    assign next_col = last ? '0 : col_t'(c_item + col_t'(1));

    // A short row ending in the spread stage may still owe writes to column 0.
    assign hazard  = job_reg.valid && job_reg.last && (job_reg.col <= col_t'(2));
    assign rd_ok   = rd_valid_reg && (rd_addr_reg == need_c);
    assign s_ready = (!m_valid_reg || m_ready) && rd_ok && !hazard;
    assign accept  = s_valid && s_ready;

    // Fetch the entry for the pixel that will be current after this edge.
    assign raddr = accept ? next_col : need_c;

    always_comb begin
        fetch = fwd_hit_reg ? fwd_data_reg : ram_rdata;
        if (q_valid_reg[0] && (q_col_reg[0] == need_c)) begin
            fetch = q_data_reg[0];
        end
        if (q_valid_reg[1] && (q_col_reg[1] == need_c)) begin
            fetch = q_data_reg[1];
        end
        x_m   = rows_on ? fetch.row1 : '0;
        y_m   = rows_on ? fetch.row2 : '0;
        cn_in = first ? '0 : carry_next_reg;
        ct_in = first ? '0 : carry_two_reg;
    end

    edd_pixel u_pixel (
        .sample         ({s_alpha_in, s_blue_in, s_green_in, s_red_in}),
        .line_err       (x_m),
        .carry_next     (cn_in),
        .carry_two      (ct_in),
        .w_next         (wts[W_NEXT]),
        .w_two          (wts[W_TWO_AHEAD]),
        .on             (on_w),
        .err            (err_w),
        .carry_next_new (cn_new),
        .carry_two_new  (ct_new)
    );

    always_comb begin
        job_next          = job_reg;
        job_next.valid    = accept;
        job_next.col      = c_item;
        job_next.last     = last;
        job_next.errs[0]  = err_w;
        for (int k = 1; k < 5; k++) begin
            job_next.errs[k] = first ? '0 : ehist_reg[k-1];
        end
        job_next.prior[0] = y_m;
        job_next.prior[1] = yhist_reg[0];
        job_next.prior[2] = yhist_reg[1];
    end

    edd_spread u_spread (
        .job (job_reg),
        .wts (wts),
        .res (spread)
    );

    // Row-end columns wait here until the memory write port is free.
    assign drain = !spread.direct_en && q_valid_reg[0];

    always_comb begin
        q_valid_next = q_valid_reg;
        q_col_next   = q_col_reg;
        q_data_next  = q_data_reg;
        if (drain) begin
            q_valid_next[0] = q_valid_reg[1];
            q_col_next[0]   = q_col_reg[1];
            q_data_next[0]  = q_data_reg[1];
            q_valid_next[1] = 1'b0;
        end
        for (int i = 0; i < 2; i++) begin
            if (spread.pend_en[i]) begin
                if (!q_valid_next[0]) begin
                    q_valid_next[0] = 1'b1;
                    q_col_next[0]   = spread.pend_col[i];
                    q_data_next[0]  = spread.pend_data[i];
                end else begin
                    q_valid_next[1] = 1'b1;
                    q_col_next[1]   = spread.pend_col[i];
                    q_data_next[1]  = spread.pend_data[i];
                end
            end
        end
    end

    assign we    = spread.direct_en || drain;
    assign waddr = spread.direct_en ? spread.direct_col : q_col_reg[0];
    assign wdata = spread.direct_en ? spread.direct_data : q_data_reg[0];

    edd_ram #(
        .WIDTH ($bits(line_t)),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg        <= width_t'(MAX_WIDTH);
            weights_low_reg  <= '0;
            weights_mid_reg  <= '0;
            weights_high_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg        <= cfg_data[WIDTH_BITS-1:0];
                CFG_WEIGHTS_LOW:  weights_low_reg  <= cfg_data;
                CFG_WEIGHTS_MID:  weights_mid_reg  <= cfg_data;
                CFG_WEIGHTS_HIGH: weights_high_reg <= cfg_data;
                default:          width_reg        <= width_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg        <= '0;
            rows_begun_reg <= '0;
            job_reg.valid  <= 1'b0;
            q_valid_reg    <= '0;
            rd_valid_reg   <= 1'b0;
            fwd_hit_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            job_reg.valid <= job_next.valid;
            q_valid_reg   <= q_valid_next;
            rd_valid_reg  <= 1'b1;
            fwd_hit_reg   <= we && (waddr == raddr);
            if (accept) begin
                col_reg     <= next_col;
                m_valid_reg <= 1'b1;
                if (last && (rb_item != 2'd2)) begin
                    rows_begun_reg <= rb_item + 2'd1;
                end else begin
                    rows_begun_reg <= rb_item;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_addr_reg   <= raddr;
        fwd_data_reg  <= wdata;
        q_col_reg     <= q_col_next;
        q_data_reg    <= q_data_next;
        job_reg.col   <= job_next.col;
        job_reg.last  <= job_next.last;
        job_reg.errs  <= job_next.errs;
        job_reg.prior <= job_next.prior;
        if (accept) begin
            carry_next_reg <= cn_new;
            carry_two_reg  <= ct_new;
            ehist_reg      <= job_next.errs[3:0];
            yhist_reg[0]   <= y_m;
            yhist_reg[1]   <= yhist_reg[0];
            on_reg         <= on_w;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_red_on   = on_reg[0];
    assign m_green_on = on_reg[1];
    assign m_blue_on  = on_reg[2];
    assign m_alpha_on = on_reg[3];
    assign cfg_ready  = 1'b1;

    // The queue has room for every row-end column it is handed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !((q_valid_reg == 2'b11) && !drain && (spread.pend_en != '0)))
        else $error("row-end queue overflow");

    // Queued row-end columns are written before the next row spreads its first column.
    assert property (@(posedge aclk) disable iff (!aresetn)
        spread.direct_en |-> !q_valid_reg[0])
        else $error("direct spread write while row-end columns are still queued");

    // Every accepted pixel beat leaves a result beat in the output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> m_valid)
        else $error("accepted pixel produced no result");

endmodule
